// File: design/ccs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types and constants for the cocktail shaker sorter.
// ----------------------------------------------------------------------------
package ccs_pkg;

  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 64;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_FWD_PRIME,
    ST_FWD_STEP,
    ST_FWD_LAST,
    ST_BWD_PRIME,
    ST_BWD_STEP,
    ST_BWD_LAST,
    ST_EMIT_RD,
    ST_EMIT_WAIT,
    ST_EMIT_HOLD
  } state_t;

  // result of one compare-exchange step
  typedef struct packed {
    logic signed [DATA_W-1:0] wr_data;
    logic signed [DATA_W-1:0] carry;
    logic                     swapped;
  } swap_res_t;

endpackage

// File: design/ccs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ccs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/ccs_swap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_swap
// Shared compare-exchange unit. Compares the carried element against the
// element just fetched and decides what is written back and what moves on.
// ----------------------------------------------------------------------------
module ccs_swap (
  input  logic                                fwd,
  input  logic signed [ccs_pkg::DATA_W-1:0]   carry,
  input  logic signed [ccs_pkg::DATA_W-1:0]   fetched,
  output ccs_pkg::swap_res_t                  res
);

  import ccs_pkg::*;

  logic signed [DATA_W-1:0] low_val;
  logic signed [DATA_W-1:0] high_val;
  logic                     out_of_order;

  // forward: carry sits below the fetched entry, backward: above it
  assign low_val      = fwd ? carry : fetched;
  assign high_val     = fwd ? fetched : carry;
  assign out_of_order = low_val > high_val;

  always_comb begin
    res.swapped = out_of_order;
    res.wr_data = out_of_order ? fetched : carry;
    res.carry   = out_of_order ? carry : fetched;
  end

endmodule

// File: design/cocktail_shaker_sorter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cocktail_shaker_sorter_top
// Collects a set of signed values, sorts it ascending by cocktail shaker
// sort with one shared compare-exchange unit, then emits it in order.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+--------------------------
//   in      | input     | in_valid / in_stall  | value, last
//   out     | output    | out_valid / out_stall| sorted_value, end_of_set
//
// loading accepts one transaction per cycle; in_stall is low only while loading
// a pass primes the carry, steps over its neighbor pairs and writes the carried
// element to the pass bound, all through the single RAM port pair
// emitting reads each result into sorted_value and holds it until out_stall is low
// reset returns to loading with an empty set; the store itself is not cleared
// ----------------------------------------------------------------------------
module cocktail_shaker_sorter_top #(
  parameter int DEPTH = ccs_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [ccs_pkg::DATA_W-1:0] value,
  input  logic                              last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ccs_pkg::DATA_W-1:0] sorted_value,
  output logic                              end_of_set
);

  import ccs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t                   state, state_next;
  logic [CW-1:0]            count, count_next;
  logic [AW-1:0]            lower_bound, lower_bound_next;
  logic [AW-1:0]            upper_bound, upper_bound_next;
  logic [AW-1:0]            idx, idx_next;
  logic [AW-1:0]            out_idx, out_idx_next;
  logic                     swap_seen, swap_seen_next;
  logic signed [DATA_W-1:0] carry, carry_next;
  logic                     out_valid_next;
  logic signed [DATA_W-1:0] sorted_value_next;
  logic                     end_of_set_next;

  logic                     we;
  logic [AW-1:0]            waddr;
  logic [DATA_W-1:0]        wdata;
  logic [AW-1:0]            raddr;
  logic [DATA_W-1:0]        rdata;
  swap_res_t                res;

  logic [CW-1:0]            count_inc;
  logic [AW-1:0]            idx_p1;
  logic [AW-1:0]            idx_m1;
  logic [AW-1:0]            upper_m1;
  logic [AW-1:0]            lower_p1;

  assign count_inc = count + CW'(1);
  assign idx_p1    = idx + AW'(1);
  assign idx_m1    = idx - AW'(1);
  assign upper_m1  = upper_bound - AW'(1);
  assign lower_p1  = lower_bound + AW'(1);
  assign in_stall  = (state != ST_LOAD);

  ccs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  ccs_swap u_swap (
    .fwd     (state == ST_FWD_STEP),
    .carry   (carry),
    .fetched ($signed(rdata)),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      count       <= '0;
      lower_bound <= '0;
      upper_bound <= '0;
      idx         <= '0;
      out_idx     <= '0;
      swap_seen   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      count       <= count_next;
      lower_bound <= lower_bound_next;
      upper_bound <= upper_bound_next;
      idx         <= idx_next;
      out_idx     <= out_idx_next;
      swap_seen   <= swap_seen_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    carry        <= carry_next;
    sorted_value <= sorted_value_next;
    end_of_set   <= end_of_set_next;
  end

  always_comb begin
    state_next        = state;
    count_next        = count;
    lower_bound_next  = lower_bound;
    upper_bound_next  = upper_bound;
    idx_next          = idx;
    out_idx_next      = out_idx;
    swap_seen_next    = swap_seen;
    carry_next        = carry;
    out_valid_next    = out_valid;
    sorted_value_next = sorted_value;
    end_of_set_next   = end_of_set;
    we                = 1'b0;
    waddr             = idx;
    wdata             = carry;
    raddr             = '0;

    case (state)
      ST_LOAD: begin
        if (in_valid) begin
          we         = 1'b1;
          waddr      = count[AW-1:0];
          wdata      = value;
          count_next = count_inc;
          if (last || count_inc == CW'(DEPTH)) begin
            out_idx_next = '0;
            if (count == '0) begin
              state_next = ST_EMIT_RD;
            end else begin
              lower_bound_next = '0;
              upper_bound_next = count[AW-1:0];
              idx_next         = '0;
              raddr            = '0;
              state_next       = ST_FWD_PRIME;
            end
          end
        end
      end

      ST_FWD_PRIME: begin
        carry_next     = $signed(rdata);
        swap_seen_next = 1'b0;
        raddr          = idx_p1;
        state_next     = ST_FWD_STEP;
      end

      ST_FWD_STEP: begin
        we         = 1'b1;
        waddr      = idx;
        wdata      = res.wr_data;
        carry_next = res.carry;
        if (res.swapped) begin
          swap_seen_next = 1'b1;
        end
        if (idx_p1 != upper_bound) begin
          idx_next = idx_p1;
          raddr    = idx_p1 + AW'(1);
        end else begin
          state_next = ST_FWD_LAST;
        end
      end

      ST_FWD_LAST: begin
        // largest element lands on the upper bound
        we               = 1'b1;
        waddr            = upper_bound;
        wdata            = carry;
        upper_bound_next = upper_m1;
        if (!swap_seen || !(lower_bound < upper_m1)) begin
          state_next = ST_EMIT_RD;
        end else begin
          idx_next   = upper_m1;
          raddr      = upper_m1;
          state_next = ST_BWD_PRIME;
        end
      end

      ST_BWD_PRIME: begin
        carry_next     = $signed(rdata);
        swap_seen_next = 1'b0;
        raddr          = idx_m1;
        state_next     = ST_BWD_STEP;
      end

      ST_BWD_STEP: begin
        we         = 1'b1;
        waddr      = idx;
        wdata      = res.wr_data;
        carry_next = res.carry;
        if (res.swapped) begin
          swap_seen_next = 1'b1;
        end
        if (idx_m1 != lower_bound) begin
          idx_next = idx_m1;
          raddr    = idx_m1 - AW'(1);
        end else begin
          state_next = ST_BWD_LAST;
        end
      end

      ST_BWD_LAST: begin
        // smallest element lands on the lower bound
        we               = 1'b1;
        waddr            = lower_bound;
        wdata            = carry;
        lower_bound_next = lower_p1;
        if (!swap_seen || !(lower_p1 < upper_bound)) begin
          state_next = ST_EMIT_RD;
        end else begin
          idx_next   = lower_p1;
          raddr      = lower_p1;
          state_next = ST_FWD_PRIME;
        end
      end

      ST_EMIT_RD: begin
        raddr      = out_idx;
        state_next = ST_EMIT_WAIT;
      end

      ST_EMIT_WAIT: begin
        sorted_value_next = $signed(rdata);
        end_of_set_next   = (CW'(out_idx) == count - CW'(1));
        out_valid_next    = 1'b1;
        state_next        = ST_EMIT_HOLD;
      end

      ST_EMIT_HOLD: begin
        if (!out_stall) begin
          out_valid_next = 1'b0;
          if (end_of_set) begin
            count_next       = '0;
            lower_bound_next = '0;
            upper_bound_next = '0;
            swap_seen_next   = 1'b0;
            state_next       = ST_LOAD;
          end else begin
            out_idx_next = out_idx + AW'(1);
            raddr        = out_idx + AW'(1);
            state_next   = ST_EMIT_WAIT;
          end
        end
      end

      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("input taken while a result is pending");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("element count beyond store depth");

  a_fwd_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FWD_STEP || state == ST_BWD_STEP) |->
      (idx <= upper_bound && idx >= lower_bound && lower_bound < upper_bound))
    else $error("compare step outside pass bounds");

  a_set_close: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && end_of_set) |=> !in_stall)
    else $error("not ready for a new set after the final transaction");
`endif

endmodule

// File: tb/ccs_sort_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_sort_checker
// Watches both channels of the cocktail shaker sorter. Every accepted input
// transaction goes into a shadow copy of the set. On the closing transaction
// (last mark or full store) the shadow set is sorted and its elements are
// queued. Each accepted output transaction is compared, field by field, with
// the oldest queued element.
// ----------------------------------------------------------------------------
module ccs_sort_checker #(
  parameter int DEPTH = ccs_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [ccs_pkg::DATA_W-1:0] value,
  input  logic                              last,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [ccs_pkg::DATA_W-1:0] sorted_value,
  input  logic                              end_of_set,
  output int                                mismatch_count,
  output int                                sorted_pending
);

  typedef struct {
    logic signed [ccs_pkg::DATA_W-1:0] val;
    logic                              tail;
  } sorted_elem_t;

  logic signed [ccs_pkg::DATA_W-1:0] set_copy [DEPTH];
  int                                set_size;
  sorted_elem_t                      sorted_q [$];

  // bidirectional bubble passes over the shadow set, shrinking both bounds
  function automatic void shaker_sort_set(int n);
    int                                lo;
    int                                hi;
    int                                i;
    logic                              moved;
    logic signed [ccs_pkg::DATA_W-1:0] t;
    lo    = 0;
    hi    = n - 1;
    moved = 1'b1;
    while (moved) begin
      moved = 1'b0;
      for (i = lo; i < hi; i++) begin
        if (set_copy[i] > set_copy[i+1]) begin
          t             = set_copy[i];
          set_copy[i]   = set_copy[i+1];
          set_copy[i+1] = t;
          moved         = 1'b1;
        end
      end
      hi--;
      if (moved) begin
        moved = 1'b0;
        for (i = hi; i > lo; i--) begin
          if (set_copy[i-1] > set_copy[i]) begin
            t             = set_copy[i];
            set_copy[i]   = set_copy[i-1];
            set_copy[i-1] = t;
            moved         = 1'b1;
          end
        end
        lo++;
      end
    end
  endfunction

  function automatic void take_element(logic signed [ccs_pkg::DATA_W-1:0] v, logic mark);
    sorted_elem_t e;
    int           k;
    if (set_size >= DEPTH) set_size = 0;
    set_copy[set_size] = v;
    set_size++;
    if (mark || set_size == DEPTH) begin
      shaker_sort_set(set_size);
      for (k = 0; k < set_size; k++) begin
        e.val  = set_copy[k];
        e.tail = (k == set_size - 1);
        sorted_q.push_back(e);
      end
      set_size = 0;
    end
  endfunction

  assign sorted_pending = sorted_q.size();

  always @(posedge clk) begin
    sorted_elem_t exp_e;
    if (rst) begin
      set_size = 0;
      sorted_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (sorted_q.size() == 0) begin
          $error("unexpected transaction: sorted_value %0d end_of_set %0b",
                 sorted_value, end_of_set);
          mismatch_count++;
        end else begin
          exp_e = sorted_q.pop_front();
          if (sorted_value !== exp_e.val) begin
            $error("sorted_value: expected %0d, got %0d", exp_e.val, sorted_value);
            mismatch_count++;
          end
          if (end_of_set !== exp_e.tail) begin
            $error("end_of_set: expected %0b, got %0b", exp_e.tail, end_of_set);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) take_element(value, last);
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives sets of signed values into the cocktail shaker sorter: a short
// directed run of corner sets, then random sets of mostly small sizes with
// a few full-store sets, under three idle/stall profiles. Checking is done
// by ccs_sort_checker.
// ----------------------------------------------------------------------------
module tb;

  localparam int DEPTH       = ccs_pkg::DEPTH_DEF;
  localparam int NUM_ITEMS   = 310;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic signed [31:0] VMIN = 32'sh8000_0000;
  localparam logic signed [31:0] VMAX = 32'sh7fff_ffff;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic signed [ccs_pkg::DATA_W-1:0] value = '0;
  logic                              last = 1'b0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [ccs_pkg::DATA_W-1:0] sorted_value;
  logic                              end_of_set;

  int mismatch_count;
  int sorted_pending;
  int cycle_count = 0;
  int items_sent  = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int phase;
  int set_len;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cocktail_shaker_sorter_top #(.DEPTH(DEPTH)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .value       (value),
    .last        (last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sorted_value(sorted_value),
    .end_of_set  (end_of_set)
  );

  ccs_sort_checker #(.DEPTH(DEPTH)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .value         (value),
    .last          (last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sorted_value  (sorted_value),
    .end_of_set    (end_of_set),
    .mismatch_count(mismatch_count),
    .sorted_pending(sorted_pending)
  );

  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // mix of full-range, tiny-range (to force equal values) and extreme values
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      6, 7:    return $signed($urandom_range(0, 6)) - 3;
      8: begin
        case ($urandom_range(0, 3))
          0:       return VMIN;
          1:       return VMAX;
          2:       return 0;
          default: return -1;
        endcase
      end
      9:       return VMIN + $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_elem(logic signed [31:0] v, logic mark);
    while ((idle_pct > 0) && ($urandom_range(0, 99) < idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    last     <= mark;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // a set of n random elements; without the mark it must be a full store
  task automatic send_random_set(int n, logic mark_end);
    int k;
    for (k = 0; k < n; k++) send_elem(pick_value(), mark_end && (k == n - 1));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    idle_pct  = 24;
    stall_pct = 46;

    // single-element sets
    send_elem(VMIN, 1'b1);
    send_elem(VMAX, 1'b1);
    send_elem(0, 1'b1);
    // reversed pair, equal pair
    send_elem(VMAX, 1'b0);
    send_elem(VMIN, 1'b1);
    send_elem(-1, 1'b0);
    send_elem(-1, 1'b1);
    // strictly descending
    send_elem(VMAX, 1'b0);
    send_elem(1, 1'b0);
    send_elem(0, 1'b0);
    send_elem(-1, 1'b0);
    send_elem(VMIN, 1'b1);
    // already ascending
    send_elem(VMIN, 1'b0);
    send_elem(-5, 1'b0);
    send_elem(5, 1'b0);
    send_elem(VMAX, 1'b1);
    // duplicates scattered
    send_elem(3, 1'b0);
    send_elem(-3, 1'b0);
    send_elem(3, 1'b0);
    send_elem(VMIN, 1'b0);
    send_elem(-3, 1'b0);
    send_elem(VMAX, 1'b1);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin idle_pct = 24; stall_pct = 46; end
        1: begin idle_pct = 46; stall_pct = 24; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      // each profile opens with one large set
      case (phase)
        0:       send_random_set(DEPTH, 1'b0);
        1:       send_random_set(DEPTH, 1'b1);
        default: send_random_set($urandom_range(40, DEPTH - 1), 1'b1);
      endcase
      while (items_sent < (NUM_ITEMS * (phase + 1)) / 3) begin
        case ($urandom_range(0, 19))
          0:           set_len = $urandom_range(1, 2);
          1, 2, 3:     set_len = $urandom_range(9, 20);
          4:           set_len = $urandom_range(21, DEPTH - 1);
          default:     set_len = $urandom_range(1, 8);
        endcase
        send_random_set(set_len, 1'b1);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (sorted_pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: cocktail_shaker_sorter_top.f
design/ccs_pkg.sv
design/ccs_ram.sv
design/ccs_swap.sv
design/cocktail_shaker_sorter_top.sv
tb/ccs_sort_checker.sv
tb/tb.sv
